FILE: rtl/spbp_pkg.sv
// ----------------------------------------------------------------------------
// spbp_pkg
// Shared constants and types for the sorted pair bound prune test: distance
// width, capacity of the cell chain, and the link and control structs of the cells.
// ----------------------------------------------------------------------------
package spbp_pkg;

    localparam int MAX_PAIRS        = 16;
    localparam int DIST_BITS        = 32;
    localparam int BOUND_INDEX_W    = 4;
    localparam int PAIR_COUNT_W     = 5;
    localparam int CNT_W            = $clog2(MAX_PAIRS + 1);
    localparam int CMP_W            = (CNT_W > PAIR_COUNT_W) ? CNT_W : PAIR_COUNT_W;

    localparam logic [PAIR_COUNT_W-1:0] PAIR_COUNT_RESET = PAIR_COUNT_W'(3);

    localparam logic ACTION_LOAD = 1'b0;
    localparam logic ACTION_PAIR = 1'b1;

    typedef logic [DIST_BITS-1:0] dist_t;

    // Data handed from one cell to its right-hand neighbour each cycle
    typedef struct packed {
        logic  occ;
        logic  min_gt;
        logic  max_gt;
        dist_t min_val;
        dist_t max_val;
    } link_t;

    // Per-cell control from the top level
    typedef struct packed {
        logic insert;
        logic clear;
        logic bound_load;
    } cell_ctrl_t;

endpackage

FILE: rtl/spbp_cell.sv
// ----------------------------------------------------------------------------
// spbp_cell
// One rank of the sorted chains: holds a minimum, a maximum, the two bounds
// of its rank and an occupancy bit; takes part in parallel insertion.
// ----------------------------------------------------------------------------
module spbp_cell (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  spbp_pkg::cell_ctrl_t ctrl,
    input  spbp_pkg::dist_t      new_min,
    input  spbp_pkg::dist_t      new_max,
    input  spbp_pkg::dist_t      load_lower,
    input  spbp_pkg::dist_t      load_upper,
    input  spbp_pkg::link_t      link_in,
    output spbp_pkg::link_t      link_out,
    output logic                 fail
);

    logic            occ_reg;
    logic            occ_next;
    spbp_pkg::dist_t min_reg;
    spbp_pkg::dist_t min_next;
    spbp_pkg::dist_t max_reg;
    spbp_pkg::dist_t max_next;
    spbp_pkg::dist_t lower_reg;
    spbp_pkg::dist_t upper_reg;
    logic            min_gt;
    logic            max_gt;
    logic            first_free;

    assign min_gt     = occ_reg && (min_reg > new_min);
    assign max_gt     = occ_reg && (max_reg > new_max);
    assign first_free = !occ_reg && link_in.occ;

    always_comb begin
        min_next = min_reg;
        max_next = max_reg;
        occ_next = occ_reg;
        if (ctrl.clear) begin
            occ_next = 1'b0;
        end else if (ctrl.insert) begin
            occ_next = occ_reg || link_in.occ;
            // shift right from the neighbour, or take the new value here
            if (link_in.min_gt) begin
                min_next = link_in.min_val;
            end else if (min_gt || first_free) begin
                min_next = new_min;
            end
            if (link_in.max_gt) begin
                max_next = link_in.max_val;
            end else if (max_gt || first_free) begin
                max_next = new_max;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg <= 1'b0;
        end else begin
            occ_reg <= occ_next;
        end
    end

    always_ff @(posedge aclk) begin
        min_reg <= min_next;
        max_reg <= max_next;
        if (ctrl.bound_load) begin
            lower_reg <= load_lower;
            upper_reg <= load_upper;
        end
    end

    assign link_out.occ     = occ_reg;
    assign link_out.min_gt  = min_gt;
    assign link_out.max_gt  = max_gt;
    assign link_out.min_val = min_reg;
    assign link_out.max_val = max_reg;

    assign fail = occ_reg && ((min_reg > upper_reg) || (max_reg < lower_reg));

endmodule

FILE: rtl/sorted_pair_bound_prune_test.sv
// ----------------------------------------------------------------------------
// sorted_pair_bound_prune_test
// Tuple pruning test over rank-sorted pair distances against bound tables.
//
// Usage: software loads the lower and upper bound tables with action 0
// transfers on the input channel (one rank per transfer, ascending ranks).
// Each tuple then arrives as one action 1 transfer per point pair; the pair's
// minimum and maximum are inserted into two sorted chains of cells, one
// pair per cycle while s_ready is high. The transfer marked last_pair starts
// the test; the result (may_match, count_error) is registered and offered on
// the m_ channel once the output register is free or being emptied. Throughput
// is one transfer per cycle, but s_ready is low while the test is pending.
// A waiting result sits in the output register: the next tuple's pairs are
// taken meanwhile, and only the next test holds until the receiver takes the
// previous result. Pairs beyond the chain capacity are dropped and flagged.
// Reset empties the chains, clears the pair counter and the output, and sets
// pair_count to 3; the bound tables are undefined until loaded.
// ----------------------------------------------------------------------------
module sorted_pair_bound_prune_test (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // configuration
    input  logic                                  cfg_wr_en,
    input  logic [spbp_pkg::PAIR_COUNT_W-1:0]     cfg_wr_data,
    // input channel
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic                                  s_action,
    input  logic [spbp_pkg::BOUND_INDEX_W-1:0]    s_bound_index,
    input  logic [spbp_pkg::DIST_BITS-1:0]        s_bound_lower_sq,
    input  logic [spbp_pkg::DIST_BITS-1:0]        s_bound_upper_sq,
    input  logic [spbp_pkg::DIST_BITS-1:0]        s_pair_min_dist,
    input  logic [spbp_pkg::DIST_BITS-1:0]        s_pair_max_dist,
    input  logic                                  s_last_pair,
    // result channel
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic                                  m_may_match,
    output logic                                  m_count_error
);

    typedef enum logic {
        ST_RUN,
        ST_TEST
    } state_t;

    state_t                                state_reg;
    logic                                  m_valid_reg;
    logic                                  may_match_reg;
    logic                                  count_error_reg;
    logic [spbp_pkg::PAIR_COUNT_W-1:0]     pair_count_reg;
    logic [spbp_pkg::CNT_W-1:0]            pairs_cnt_reg;
    logic                                  overflow_reg;

    logic                                  in_xfer;
    logic                                  pair_xfer;
    logic                                  load_xfer;
    logic                                  store_full;
    logic                                  do_insert;
    logic                                  result_load;
    logic                                  any_fail;
    logic                                  count_mismatch;

    spbp_pkg::link_t                       chain [0:spbp_pkg::MAX_PAIRS];
    spbp_pkg::cell_ctrl_t                  cell_ctrl [0:spbp_pkg::MAX_PAIRS-1];
    logic [spbp_pkg::MAX_PAIRS-1:0]        fail_vec;
    logic [spbp_pkg::MAX_PAIRS-1:0]        occ_vec;

    // Handshake: take transfers except while the rank compare is pending
    assign s_ready   = (state_reg == ST_RUN);
    assign in_xfer   = s_valid && s_ready;
    assign pair_xfer = in_xfer && (s_action == spbp_pkg::ACTION_PAIR);
    assign load_xfer = in_xfer && (s_action == spbp_pkg::ACTION_LOAD);

    assign store_full = (pairs_cnt_reg == spbp_pkg::CNT_W'(spbp_pkg::MAX_PAIRS));
    assign do_insert  = pair_xfer && !store_full;

    // Load the result once the output register is free (or being emptied)
    assign result_load = (state_reg == ST_TEST) && (!m_valid_reg || m_ready);

    // The left edge of the chain behaves as an occupied cell that never shifts
    assign chain[0] = '{occ: 1'b1, min_gt: 1'b0, max_gt: 1'b0,
                        min_val: '0, max_val: '0};

    for (genvar i = 0; i < spbp_pkg::MAX_PAIRS; i++) begin : g_cell
        assign cell_ctrl[i].insert     = do_insert;
        assign cell_ctrl[i].clear      = result_load;
        assign cell_ctrl[i].bound_load = load_xfer && (int'(s_bound_index) == i);

        spbp_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctrl       (cell_ctrl[i]),
            .new_min    (s_pair_min_dist),
            .new_max    (s_pair_max_dist),
            .load_lower (s_bound_lower_sq),
            .load_upper (s_bound_upper_sq),
            .link_in    (chain[i]),
            .link_out   (chain[i+1]),
            .fail       (fail_vec[i])
        );

        assign occ_vec[i] = chain[i+1].occ;
    end

    // Any occupied rank out of bounds prunes the tuple
    assign any_fail = |fail_vec;
    assign count_mismatch = (spbp_pkg::CMP_W'(pairs_cnt_reg) !=
                             spbp_pkg::CMP_W'(pair_count_reg));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg          <= ST_RUN;
            m_valid_reg        <= 1'b0;
            may_match_reg      <= 1'b0;
            count_error_reg    <= 1'b0;
            pair_count_reg     <= spbp_pkg::PAIR_COUNT_RESET;
            pairs_cnt_reg      <= '0;
            overflow_reg       <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                pair_count_reg <= cfg_wr_data;
            end

            // present a fresh result, or drop the old one once the receiver has taken it
            if (result_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_RUN: begin
                    if (pair_xfer) begin
                        if (store_full) begin
                            overflow_reg <= 1'b1;
                        end else begin
                            pairs_cnt_reg <= pairs_cnt_reg + spbp_pkg::CNT_W'(1);
                        end
                        if (s_last_pair) begin
                            state_reg <= ST_TEST;
                        end
                    end
                end
                ST_TEST: begin
                    if (result_load) begin
                        may_match_reg      <= !any_fail;
                        count_error_reg    <= overflow_reg || count_mismatch;
                        pairs_cnt_reg      <= '0;
                        overflow_reg       <= 1'b0;
                        state_reg          <= ST_RUN;
                    end
                end
                default: begin
                    state_reg <= ST_RUN;
                end
            endcase
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_may_match   = may_match_reg;
    assign m_count_error = count_error_reg;

`ifndef ASSERT_OFF
    // Occupied cells always match the pair counter
    a_occ_matches_count: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(occ_vec) == int'(pairs_cnt_reg))
        else $error("cell occupancy differs from pair counter");

    // Occupancy fills from the left with no gaps
    a_occ_contiguous: assert property (@(posedge aclk) disable iff (!aresetn)
        ((occ_vec & (occ_vec + spbp_pkg::MAX_PAIRS'(1))) == '0))
        else $error("cell occupancy is not contiguous");

    // Overflow only once the chain is full
    a_overflow_full: assert property (@(posedge aclk) disable iff (!aresetn)
        overflow_reg |-> store_full)
        else $error("overflow flagged with free cells");

    // A last pair transfer moves to the test
    a_last_starts_test: assert property (@(posedge aclk) disable iff (!aresetn)
        (pair_xfer && s_last_pair) |=> (state_reg == ST_TEST))
        else $error("last pair did not start the test");

    // Loading a result empties the tuple state and presents the result
    a_result_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        result_load |=> (pairs_cnt_reg == '0) && !overflow_reg && m_valid_reg)
        else $error("tuple state not cleared after test");
`endif

endmodule
